### hdl/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int MODE_W       = 1;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctl;

endpackage

`default_nettype wire

### hdl/spq_cell.sv
`default_nettype none

module spq_cell #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0
) (
    input  wire                                       i_clk,
    input  wire  spq_pkg::t_cell_ctl                  i_ctl,
    input  wire  [$clog2(CAPACITY+1)-1:0]             i_count,
    input  wire  signed [spq_pkg::DATA_W-1:0]         i_new_value,
    input  wire  signed [spq_pkg::DATA_W-1:0]         i_new_rank,
    input  wire                                       i_left_ge,
    input  wire  signed [spq_pkg::DATA_W-1:0]         i_left_value,
    input  wire  signed [spq_pkg::DATA_W-1:0]         i_left_rank,
    input  wire  signed [spq_pkg::DATA_W-1:0]         i_right_value,
    input  wire  signed [spq_pkg::DATA_W-1:0]         i_right_rank,
    output logic                                      o_ge,
    output logic signed [spq_pkg::DATA_W-1:0]         o_value,
    output logic signed [spq_pkg::DATA_W-1:0]         o_rank
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] r_rank;
    logic signed [DATA_W-1:0] n_value;
    logic signed [DATA_W-1:0] n_rank;
    logic                     w_occupied;

    always_comb begin
        w_occupied = (CW'(INDEX) < i_count);
        o_ge       = w_occupied && (r_rank >= i_new_rank);
        n_value    = r_value;
        n_rank     = r_rank;
        if (i_ctl.remove) begin
            n_value = i_right_value;
            n_rank  = i_right_rank;
        end else if (i_ctl.insert && !o_ge) begin
            if (i_left_ge) begin
                n_value = i_new_value;
                n_rank  = i_new_rank;
            end else begin
                n_value = i_left_value;
                n_rank  = i_left_rank;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_rank  <= n_rank;
    end

    assign o_value = r_value;
    assign o_rank  = r_rank;

endmodule

`default_nettype wire

### hdl/sorted_priority_queue.sv
`default_nettype none

// Bounded priority queue held as a row of CAPACITY cells in service order. An insert
// request places its entry after every stored entry of greater or equal priority, so
// equal priorities leave in arrival order; a remove request returns the head entry.
// Every request yields one result with a status and the occupancy after the request.
// The block accepts one request per clock while o_stall is low; its result is registered
// and appears in the next cycle. All cells compare against the new priority and shift
// in parallel. A full insert or an empty remove leaves the queue as it is.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire  [spq_pkg::MODE_W-1:0]            i_mode,
    input  wire  signed [spq_pkg::DATA_W-1:0]     i_item_value,
    input  wire  signed [spq_pkg::DATA_W-1:0]     i_item_rank,
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic signed [spq_pkg::DATA_W-1:0]     o_taken_value,
    output logic signed [spq_pkg::DATA_W-1:0]     o_taken_rank,
    output logic [spq_pkg::STATUS_W-1:0]          o_status,
    output logic [spq_pkg::OCC_W-1:0]             o_occupancy
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_taken_value;
    logic signed [DATA_W-1:0] r_taken_rank;
    logic [STATUS_W-1:0]      r_status;
    logic [STATUS_W-1:0]      n_status;

    logic                     w_accept;
    t_cell_ctl                w_ctl;

    logic                     w_ge         [CAPACITY];
    logic signed [DATA_W-1:0] w_value      [CAPACITY];
    logic signed [DATA_W-1:0] w_rank       [CAPACITY];
    logic                     w_left_ge    [CAPACITY];
    logic signed [DATA_W-1:0] w_left_value [CAPACITY];
    logic signed [DATA_W-1:0] w_left_rank  [CAPACITY];
    logic signed [DATA_W-1:0] w_right_value[CAPACITY];
    logic signed [DATA_W-1:0] w_right_rank [CAPACITY];

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        w_ctl.insert = w_accept && (i_mode == MODE_INSERT) && (r_count != FULL_COUNT);
        w_ctl.remove = w_accept && (i_mode == MODE_REMOVE) && (r_count != '0);
        n_count  = r_count;
        n_status = ST_DONE;
        if (w_ctl.insert) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.remove) begin
            n_count = r_count - CW'(1);
        end else if (i_mode == MODE_INSERT) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_EMPTY;
        end
    end

    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            if (k == 0) begin
                w_left_ge[k]    = 1'b1;
                w_left_value[k] = '0;
                w_left_rank[k]  = '0;
            end else begin
                w_left_ge[k]    = w_ge[k-1];
                w_left_value[k] = w_value[k-1];
                w_left_rank[k]  = w_rank[k-1];
            end
            if (k == CAPACITY - 1) begin
                w_right_value[k] = '0;
                w_right_rank[k]  = '0;
            end else begin
                w_right_value[k] = w_value[k+1];
                w_right_rank[k]  = w_rank[k+1];
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_count       (r_count),
            .i_new_value   (i_item_value),
            .i_new_rank    (i_item_rank),
            .i_left_ge     (w_left_ge[g]),
            .i_left_value  (w_left_value[g]),
            .i_left_rank   (w_left_rank[g]),
            .i_right_value (w_right_value[g]),
            .i_right_rank  (w_right_rank[g]),
            .o_ge          (w_ge[g]),
            .o_value       (w_value[g]),
            .o_rank        (w_rank[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            if (w_ctl.remove) begin
                r_taken_value <= w_value[0];
                r_taken_rank  <= w_rank[0];
            end else begin
                r_taken_value <= '0;
                r_taken_rank  <= '0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_taken_value = r_taken_value;
    assign o_taken_rank  = r_taken_rank;
    assign o_status      = r_status;
    assign o_occupancy   = OCC_W'(r_count);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("Occupancy exceeds capacity.");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_mode == MODE_REMOVE) && (r_count == '0))
        |=> (o_valid && (o_status == ST_EMPTY) && (r_count == '0)))
        else $error("Remove on an empty queue was not flagged.");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_mode == MODE_INSERT) && (r_count == FULL_COUNT))
        |=> (o_valid && (o_status == ST_FULL) && (r_count == FULL_COUNT)))
        else $error("Insert on a full queue was not flagged.");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.insert |=> (r_count == $past(r_count) + CW'(1)))
        else $error("Successful insert did not raise the occupancy by one.");
`endif

endmodule

`default_nettype wire
